// ----- hdl/sorted_state_index_search_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the sorted state index search
// Shared property forms, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SORTED_STATE_INDEX_SEARCH_TOP_DEFINES_SVH
`define SORTED_STATE_INDEX_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication
`define SSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/sssrch_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted state index search package
// Field widths, parameter defaults, request codes, sequencer states and the
// highest-set-bit helper.
// ----------------------------------------------------------------------------
package sssrch_pkg;

  localparam int KEY_W = 32;
  localparam int TOP_W = 5;

  localparam int SITES_DEF       = 32;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int LOOKUP_BITS_DEF = 10;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_Q_RDHI,
    S_Q_HI,
    S_Q_MID,
    S_Q_CMP,
    S_L_CLOSE,
    S_L_OPEN,
    S_L_COMMIT,
    S_DONE
  } st_e;

  // Index of the highest set bit; zero for an all-zero word
  function automatic logic [TOP_W-1:0] high_bit(input logic [KEY_W-1:0] k);
    logic [TOP_W-1:0] r;
    r = '0;
    for (int i = 0; i < KEY_W; i++) begin
      if (k[i]) begin
        r = TOP_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ----- hdl/sorted_state_index_search_top.sv -----
// Query: rejected at the checks, else two bound reads followed by binary-search
// probes until one matches or the range is empty.
// Load: rejected at the checks, else bounds slots are written, then the entry;
// at most 2 * 2^EFF_BITS slots per load. The next request is taken after the result.
// Reset clears the count, bucket flags and handshake state; both RAMs keep
// their contents and need no clearing pass.
// ----------------------------------------------------------------------------
// Sorted state index search, top level
// Loads strictly descending bit words and finds a word by bucket lookup
// followed by a binary search over the entry RAM.
// ----------------------------------------------------------------------------
`include "sorted_state_index_search_top_defines.svh"

module sorted_state_index_search_top #(
  parameter int SITES       = sssrch_pkg::SITES_DEF,
  parameter int TABLE_DEPTH = sssrch_pkg::TABLE_DEPTH_DEF,
  parameter int LOOKUP_BITS = sssrch_pkg::LOOKUP_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               operation_i,
  input  logic [sssrch_pkg::KEY_W-1:0]       key_word_i,
  input  logic [sssrch_pkg::TOP_W-1:0]       top_site_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [$clog2(TABLE_DEPTH+1)-1:0]   position_o,
  output logic                               found_o
);

  import sssrch_pkg::*;

  localparam int NBUCKETS  = SITES + 1;
  localparam int EFF_BITS  = (LOOKUP_BITS < NBUCKETS) ? LOOKUP_BITS : NBUCKETS;
  localparam int FULL_SUB  = 1 << EFF_BITS;
  localparam int SLOTS     = FULL_SUB + 1;
  localparam int BND_DEPTH = NBUCKETS * SLOTS;
  localparam int POS_W     = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int ADDR_W    = $clog2(BND_DEPTH);
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int BKT_W     = $clog2(NBUCKETS);

  st_e state_q, state_d;

  logic               op_q, op_d;
  logic [KEY_W-1:0]   key_q, key_d;
  logic [TOP_W-1:0]   hint_q, hint_d;
  logic [TOP_W-1:0]   t_q, t_d;
  logic               nz_q, nz_d;
  logic [EFF_BITS-1:0] v_q, v_d;

  logic [POS_W-1:0]   count_q, count_d;
  logic [KEY_W-1:0]   last_q, last_d;
  logic [TOP_W-1:0]   lt_q, lt_d;
  logic [EFF_BITS-1:0] ps_q, ps_d;
  logic [NBUCKETS-1:0] bvalid_q, bvalid_d;

  logic [SLOT_W-1:0]  w_q, w_d;
  logic [SLOT_W-1:0]  upper_q, upper_d;
  logic [POS_W-1:0]   lo_q, lo_d;
  logic [POS_W-1:0]   hi_q, hi_d;
  logic [POS_W-1:0]   mid_q, mid_d;

  logic [POS_W-1:0]   res_pos_q, res_pos_d;
  logic               res_found_q, res_found_d;
  logic               out_valid_q, out_valid_d;
  logic [POS_W-1:0]   out_pos_q, out_pos_d;
  logic               out_found_q, out_found_d;

  // RAM ports
  logic               ent_we;
  logic [IDX_W-1:0]   ent_waddr, ent_raddr;
  logic [KEY_W-1:0]   ent_rdata;
  logic               bnd_we;
  logic [ADDR_W-1:0]  bnd_waddr, bnd_raddr;
  logic [POS_W-1:0]   bnd_rdata;

  // Shared decisions
  logic [TOP_W:0]     tp1;
  logic [TOP_W:0]     shamt;
  logic [KEY_W-1:0]   sub_full;
  logic [EFF_BITS-1:0] sub_c;
  logic [BKT_W-1:0]   bkt;
  logic               have_last;
  logic               same_bkt;
  logic               site_bad;
  logic               q_rej, l_rej, l_close, l_open;
  logic [SLOT_W-1:0]  upper_c;
  logic               lo_ovr, hi_ovr;
  logic [POS_W-1:0]   hi_raw;
  logic [POS_W-1:0]   mid_c;
  logic               range_empty;
  logic               key_eq, key_gt;
  logic               close_end, open_end;
  logic               out_free;

  function automatic logic [ADDR_W-1:0] bnd_addr(input logic [TOP_W-1:0]  b,
                                                 input logic [SLOT_W-1:0] w);
    return ADDR_W'(b) * ADDR_W'(SLOTS) + ADDR_W'(w);
  endfunction

  sssrch_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (key_q),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  sssrch_ram #(
    .WIDTH (POS_W),
    .DEPTH (BND_DEPTH)
  ) u_bound_ram (
    .clk_i   (clk_i),
    .we_i    (bnd_we),
    .waddr_i (bnd_waddr),
    .wdata_i (count_q),
    .raddr_i (bnd_raddr),
    .rdata_o (bnd_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign position_o  = out_pos_q;
  assign found_o     = out_found_q;

  // Sub-key: keep the top EFF_BITS significant bits below and at the top bit
  assign tp1      = {1'b0, t_q} + (TOP_W+1)'(1);
  assign shamt    = (tp1 > (TOP_W+1)'(EFF_BITS)) ? tp1 - (TOP_W+1)'(EFF_BITS) : '0;
  assign sub_full = key_q >> shamt;
  assign sub_c    = sub_full[EFF_BITS-1:0];
  assign bkt      = BKT_W'(t_q);

  assign have_last = (count_q != '0);
  assign same_bkt  = have_last && (lt_q == t_q);
  assign site_bad  = (32'(t_q) >= 32'(SITES));

  assign q_rej = !have_last || !nz_q || site_bad || (t_q != hint_q) || !bvalid_q[bkt];
  assign l_rej = (count_q >= POS_W'(TABLE_DEPTH)) || !nz_q || site_bad ||
                 (have_last && (key_q >= last_q));
  assign l_close = have_last && (lt_q != t_q);
  assign upper_c = same_bkt ? SLOT_W'(ps_q) : SLOT_W'(FULL_SUB);
  assign l_open  = (SLOT_W'(sub_c) + SLOT_W'(1)) <= upper_c;

  // The open bucket's low slots are not written yet: they read as the count
  assign lo_ovr = same_bkt && ((SLOT_W'(v_q) + SLOT_W'(1)) <= SLOT_W'(ps_q));
  assign hi_ovr = same_bkt && (v_q <= ps_q);
  assign hi_raw = hi_ovr ? count_q : bnd_rdata;

  assign mid_c       = lo_q + ((hi_q - lo_q) >> 1);
  assign range_empty = (lo_q >= hi_q);
  assign key_eq      = (ent_rdata == key_q);
  assign key_gt      = (ent_rdata > key_q);

  assign close_end = (w_q == SLOT_W'(ps_q));
  assign open_end  = (w_q == upper_q);
  assign out_free  = !out_valid_q || out_ready_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: state_d = S_CHECK;
      S_CHECK: begin
        if (op_q == OP_QUERY) begin
          state_d = q_rej ? S_DONE : S_Q_RDHI;
        end else if (l_rej) begin
          state_d = S_DONE;
        end else if (l_close) begin
          state_d = S_L_CLOSE;
        end else if (l_open) begin
          state_d = S_L_OPEN;
        end else begin
          state_d = S_L_COMMIT;
        end
      end
      S_Q_RDHI: state_d = S_Q_HI;
      S_Q_HI:   state_d = S_Q_MID;
      S_Q_MID:  state_d = range_empty ? S_DONE : S_Q_CMP;
      S_Q_CMP:  state_d = key_eq ? S_DONE : S_Q_MID;
      S_L_CLOSE: begin
        if (close_end) begin
          state_d = S_L_OPEN;
        end
      end
      S_L_OPEN: begin
        if (open_end) begin
          state_d = S_L_COMMIT;
        end
      end
      S_L_COMMIT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    hint_d      = hint_q;
    t_d         = t_q;
    nz_d        = nz_q;
    v_d         = v_q;
    count_d     = count_q;
    last_d      = last_q;
    lt_d        = lt_q;
    ps_d        = ps_q;
    bvalid_d    = bvalid_q;
    w_d         = w_q;
    upper_d     = upper_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_pos_d   = out_pos_q;
    out_found_d = out_found_q;

    ent_we    = 1'b0;
    ent_waddr = count_q[IDX_W-1:0];
    ent_raddr = mid_c[IDX_W-1:0];
    bnd_we    = 1'b0;
    bnd_waddr = bnd_addr(t_q, w_q);
    bnd_raddr = bnd_addr(t_q, SLOT_W'(sub_c) + SLOT_W'(1));

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          op_d   = operation_i;
          key_d  = key_word_i;
          hint_d = top_site_i;
        end
      end
      S_DECODE: begin
        t_d  = high_bit(key_q);
        nz_d = |key_q;
      end
      S_CHECK: begin
        v_d         = sub_c;
        res_pos_d   = count_q;
        res_found_d = 1'b0;
        upper_d     = l_close ? SLOT_W'(FULL_SUB) : upper_c;
        w_d         = l_close ? '0 : SLOT_W'(sub_c) + SLOT_W'(1);
      end
      S_Q_RDHI: begin
        // lower bound arrives, ask for the upper one
        bnd_raddr = bnd_addr(t_q, SLOT_W'(v_q));
        lo_d      = lo_ovr ? count_q : bnd_rdata;
      end
      S_Q_HI: begin
        hi_d = (hi_raw > count_q) ? count_q : hi_raw;
      end
      S_Q_MID: begin
        mid_d = mid_c;
      end
      S_Q_CMP: begin
        if (key_eq) begin
          res_pos_d   = mid_q;
          res_found_d = 1'b1;
        end else if (key_gt) begin
          lo_d = mid_q + POS_W'(1);
        end else begin
          hi_d = mid_q;
        end
      end
      S_L_CLOSE: begin
        // close the previous bucket: all its slots up to its last sub-key
        bnd_we    = 1'b1;
        bnd_waddr = bnd_addr(lt_q, w_q);
        w_d       = close_end ? SLOT_W'(v_q) + SLOT_W'(1) : w_q + SLOT_W'(1);
      end
      S_L_OPEN: begin
        bnd_we    = 1'b1;
        bnd_waddr = bnd_addr(t_q, w_q);
        w_d       = w_q + SLOT_W'(1);
      end
      S_L_COMMIT: begin
        ent_we        = 1'b1;
        count_d       = count_q + POS_W'(1);
        last_d        = key_q;
        lt_d          = t_q;
        ps_d          = v_q;
        bvalid_d[bkt] = 1'b1;
        res_pos_d     = count_q;
        res_found_d   = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pos_d   = res_pos_q;
          out_found_d = res_found_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      bvalid_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      bvalid_q    <= bvalid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    hint_q      <= hint_d;
    t_q         <= t_d;
    nz_q        <= nz_d;
    v_q         <= v_d;
    last_q      <= last_d;
    lt_q        <= lt_d;
    ps_q        <= ps_d;
    w_q         <= w_d;
    upper_q     <= upper_d;
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    out_pos_q   <= out_pos_d;
    out_found_q <= out_found_d;
  end

  `SSS_ASSERT_NXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready held after accept")
  `SSS_ASSERT_IMP(a_probe_in_table, state_q == S_Q_CMP, mid_q < count_q, "probe beyond entry count")
  `SSS_ASSERT_IMP(a_found_in_table, out_valid_o && found_o, position_o < count_q, "found position beyond count")
  `SSS_ASSERT_IMP(a_count_step, count_q != $past(count_q), count_q == $past(count_q) + 1, "entry count jumped")

endmodule

// ----- hdl/sssrch_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sssrch_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// Testbench for the sorted state index search
// Loads descending bit words and queries them through the valid/ready
// channels. Every request is checked against an in-bench copy of the bucket
// index and binary search. The run covers an empty table, rejected loads,
// targeted query cases and mixed random traffic.
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  import sssrch_pkg::*;

  localparam int HALF_PERIOD = 2;
  localparam int SITE_COUNT  = SITES_DEF;
  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int POS_W       = $clog2(DEPTH + 1);
  localparam int BUCKETS     = SITE_COUNT + 1;
  localparam int SUB_BITS    = (LOOKUP_BITS_DEF < BUCKETS) ? LOOKUP_BITS_DEF : BUCKETS;
  localparam int SUB_TOP     = 1 << SUB_BITS;
  localparam int SLOT_ROW    = SUB_TOP + 1;
  localparam int FLOOR_BIT   = 14;
  localparam logic [KEY_W-1:0] FLOOR_KEY = 32'h1 << FLOOR_BIT;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             found;
  } answer_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic              operation_i;
  logic [KEY_W-1:0]  key_word_i;
  logic [TOP_W-1:0]  top_site_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [POS_W-1:0]  position_o;
  logic              found_o;

  // Mirror of the table and its bucket index
  logic [KEY_W-1:0]  stored_words [DEPTH];
  int unsigned       stored_total;
  int unsigned       first_below [BUCKETS*SLOT_ROW];
  bit                bucket_seen [BUCKETS];

  answer_t           pending_answers[$];
  int                burst_left;
  int                failures;
  int                loads_taken;
  int                loads_refused;
  int                query_hits;
  int                query_misses;

  sorted_state_index_search_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_word_i  (key_word_i),
    .top_site_i  (top_site_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .position_o  (position_o),
    .found_o     (found_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  function automatic int top_index(logic [KEY_W-1:0] k);
    int t;
    t = -1;
    for (int i = 0; i < KEY_W; i++) begin
      if (k[i]) begin
        t = i;
      end
    end
    return t;
  endfunction

  // Keep only the top SUB_BITS significant bits of the word
  function automatic int unsigned sub_of(logic [KEY_W-1:0] k, int t);
    int unsigned s;
    s = (t + 1 > SUB_BITS) ? t + 1 - SUB_BITS : 0;
    return k >> s;
  endfunction

  // First index in bucket t whose sub-key is below w; the open bucket ends at the count
  function automatic int unsigned bound_of(int t, int unsigned w);
    logic [KEY_W-1:0] last;
    int lt;
    if (stored_total > 0) begin
      last = stored_words[stored_total-1];
      lt = top_index(last);
      if (lt == t && w <= sub_of(last, lt)) begin
        return stored_total;
      end
    end
    return first_below[t*SLOT_ROW + w];
  endfunction

  function automatic void fill_slots(int t, int unsigned from, int unsigned to,
                                     int unsigned idx);
    for (int unsigned w = from; w <= to && w < SLOT_ROW; w++) begin
      first_below[t*SLOT_ROW + w] = idx;
    end
  endfunction

  function automatic answer_t predict_load(logic [KEY_W-1:0] key);
    answer_t a;
    int unsigned n, v, upper, ps;
    int t, pt;
    logic [KEY_W-1:0] last;
    n = stored_total;
    t = top_index(key);
    upper = SUB_TOP;
    a.position = POS_W'(n);
    a.found = 1'b0;
    if (n >= DEPTH || t < 0 || t >= SITE_COUNT) begin
      return a;
    end
    v = sub_of(key, t);
    if (n > 0) begin
      last = stored_words[n-1];
      if (key >= last) begin
        return a;
      end
      pt = top_index(last);
      ps = sub_of(last, pt);
      // close the previous bucket, or continue below its last sub-key
      if (pt != t) begin
        fill_slots(pt, 0, ps, n);
      end else begin
        upper = ps;
      end
    end
    if (v + 1 <= upper) begin
      fill_slots(t, v + 1, upper, n);
    end
    bucket_seen[t] = 1'b1;
    stored_words[n] = key;
    stored_total = n + 1;
    a.found = 1'b1;
    return a;
  endfunction

  function automatic answer_t predict_query(logic [KEY_W-1:0] key, logic [TOP_W-1:0] hint);
    answer_t a;
    int t;
    int unsigned v, lo, hi, mid;
    logic [KEY_W-1:0] e;
    a.position = POS_W'(stored_total);
    a.found = 1'b0;
    t = top_index(key);
    if (stored_total == 0 || t < 0 || t >= SITE_COUNT || t != int'(hint)) begin
      return a;
    end
    if (!bucket_seen[t]) begin
      return a;
    end
    v = sub_of(key, t);
    lo = bound_of(t, v + 1);
    hi = bound_of(t, v);
    if (hi > stored_total) begin
      hi = stored_total;
    end
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      e = stored_words[mid];
      if (e == key) begin
        a.position = POS_W'(mid);
        a.found = 1'b1;
        return a;
      end
      if (e > key) begin
        lo = mid + 1;
      end else begin
        hi = mid;
      end
    end
    return a;
  endfunction

  // Called at a rising edge; returns at the edge that accepts the request
  task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                              input logic [TOP_W-1:0] hint);
    logic taken;
    answer_t a;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    operation_i <= op;
    key_word_i  <= key;
    top_site_i  <= hint;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (taken !== 1'b1);
    if (op == OP_QUERY) begin
      a = predict_query(key, hint);
      if (a.found) query_hits++;
      else query_misses++;
    end else begin
      a = predict_load(key);
      if (a.found) loads_taken++;
      else loads_refused++;
    end
    pending_answers.push_back(a);
  endtask

  // Hold the sender off until every outstanding request has been answered
  task automatic await_all_answers();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // Mostly stored words, some neighbours, random and zero words, some wrong hints
  task automatic pick_probe(output logic [KEY_W-1:0] key, output logic [TOP_W-1:0] hint);
    int sel;
    sel = $urandom_range(0, 99);
    if (stored_total > 0 && sel < 55) begin
      key = stored_words[$urandom_range(0, stored_total - 1)];
    end else if (stored_total > 0 && sel < 70) begin
      key = stored_words[$urandom_range(0, stored_total - 1)];
      key = $urandom_range(0, 1) ? key + 1 : key - 1;
    end else begin
      key = $urandom >> $urandom_range(0, 31);
    end
    hint = TOP_W'(top_index(key));
    if (sel >= 95 || key == '0) begin
      key = '0;
      hint = TOP_W'($urandom);
    end else if (sel >= 87) begin
      hint = TOP_W'($urandom);
    end
  endtask

  task automatic test_empty_table();
    send_request(OP_QUERY, 32'hFFFF_FFFF, 5'd31);
    send_request(OP_QUERY, 32'h0000_0000, 5'd0);
    send_request(OP_LOAD,  32'h0000_0000, 5'd0);
  endtask

  task automatic test_load_ordering();
    send_request(OP_LOAD,  32'hFFFF_FFFF, 5'd0);
    send_request(OP_LOAD,  32'hFFFF_FFFF, 5'd31);
    send_request(OP_LOAD,  32'hFFFF_FFFE, TOP_W'($urandom));
    send_request(OP_LOAD,  32'hFFFF_FFFD, TOP_W'($urandom));
    // match on the last index of the still open bucket
    send_request(OP_QUERY, 32'hFFFF_FFFD, 5'd31);
    send_request(OP_QUERY, 32'hFFFF_FFFC, 5'd31);
    send_request(OP_LOAD,  32'hFFC0_0000, 5'd31);
    send_request(OP_LOAD,  32'hFFBF_FFFF, 5'd31);
    send_request(OP_LOAD,  32'h7FFF_FFFF, 5'd30);
    send_request(OP_LOAD,  32'h8000_0000, 5'd31);
    send_request(OP_LOAD,  32'h0000_0000, 5'd31);
  endtask

  task automatic test_query_cases();
    // last entry of a closed sub-key range
    send_request(OP_QUERY, 32'hFFC0_0000, 5'd31);
    send_request(OP_QUERY, 32'hFFFF_FFFF, 5'd31);
    send_request(OP_QUERY, 32'hFFFF_FFFF, 5'd30);
    send_request(OP_QUERY, 32'hFFFF_FFFF, 5'd0);
    send_request(OP_QUERY, 32'h7FFF_FFFF, 5'd30);
    send_request(OP_QUERY, 32'h0000_0001, 5'd0);
    send_request(OP_QUERY, 32'h0000_FFFF, 5'd15);
    send_request(OP_QUERY, 32'h0000_0000, 5'd0);
    send_request(OP_QUERY, 32'h8000_0000, 5'd31);
    send_request(OP_QUERY, 32'hFFBF_FFFF, 5'd31);
  endtask

  task automatic test_random_traffic(input int count);
    logic [KEY_W-1:0] last, key;
    logic [TOP_W-1:0] hint;
    int t, sel;
    int unsigned step;
    bit as_query;
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) begin
        await_all_answers();
      end
      as_query = ($urandom_range(0, 99) >= 55);
      if (!as_query) begin
        last = stored_words[stored_total-1];
        t = top_index(last);
        sel = $urandom_range(0, 199);
        if (sel < 8) begin
          key = '0;
        end else if (sel < 16) begin
          key = last + $urandom_range(0, 32'hFFFF_FFFF - last);
        end else if (sel < 19 && t > FLOOR_BIT) begin
          // drop into the next bucket down
          key = (32'h1 << (t - 1)) | ($urandom & ((32'h1 << (t - 1)) - 1));
        end else begin
          if (sel < 140) step = $urandom_range(1, 4);
          else if (sel < 185) step = $urandom_range(1, 1 << (t - 9));
          else step = $urandom_range(1, 1 << (t - 4));
          if (last >= step + FLOOR_KEY) key = last - step;
          else as_query = 1'b1;
        end
      end
      if (as_query) begin
        pick_probe(key, hint);
        send_request(OP_QUERY, key, hint);
      end else begin
        send_request(OP_LOAD, key, TOP_W'($urandom));
      end
    end
  endtask

  initial begin : receiver
    int mode;
    out_ready_i <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(32, 400)) begin
        @(posedge clk_i);
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= ($urandom_range(0, 15) != 0);
        endcase
      end
    end
  end

  initial begin : check_results
    answer_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i === 1'b1) begin
        if (pending_answers.size() == 0) begin
          $error("result with no request outstanding: position %0d found %0b",
                 position_o, found_o);
          failures++;
        end else begin
          want = pending_answers.pop_front();
          if (position_o !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, position_o);
            failures++;
          end
          if (found_o !== want.found) begin
            $error("found: expected %0b, got %0b", want.found, found_o);
            failures++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    #6ms;
    $display("sorted_state_index_search_top verification failed");
    $finish;
  end

  initial begin : run_tests
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    operation_i <= OP_LOAD;
    key_word_i  <= '0;
    top_site_i  <= '0;
    burst_left  = 0;
    failures    = 0;
    stored_total = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_load_ordering();
    test_query_cases();
    await_all_answers();
    test_random_traffic(1550);
    await_all_answers();
    repeat (40) @(posedge clk_i);
    $display("Loads: %0d stored, %0d refused; queries: %0d hits, %0d misses",
             loads_taken, loads_refused, query_hits, query_misses);
    $display("Table ended with %0d of %0d entries", stored_total, DEPTH);
    if (failures == 0 && pending_answers.size() == 0) begin
      $display("sorted_state_index_search_top verification clean");
    end else begin
      $display("sorted_state_index_search_top verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/sssrch_pkg.sv
hdl/sssrch_ram.sv
hdl/sorted_state_index_search_top.sv
verif/tb_top.sv
